@@ design/assert_macros.svh @@
// Assertion macros shared by the schedule table RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define SST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sst_pkg.sv @@
// Types and codes for the sorted schedule table.
// No dependencies; used by sst_cell and sorted_schedule_table.
`default_nettype none

package sst_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;

  // Input beat
  typedef struct packed {
    logic [1:0]  command;
    logic [10:0] minute_of_day;
    logic [6:0]  day_mask;
    logic [3:0]  position;
  } sst_in_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        matched;
    logic [10:0] found_time;
    logic [6:0]  found_days;
    logic [4:0]  entry_count;
  } sst_out_t;

  // One stored schedule entry
  typedef struct packed {
    logic [10:0] slot_time;
    logic [6:0]  slot_days;
  } sst_entry_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic        ins;
    logic        rem;
    logic [10:0] key;
    logic [6:0]  days;
  } sst_ctrl_t;

endpackage

`default_nettype wire

@@ design/sst_cell.sv @@
// One slot of the schedule table: holds an entry and shifts with its neighbors.
// Depends on sst_pkg for the entry and control types.
`default_nettype none

module sst_cell #(
  parameter int IDX = 0,
  parameter int WW  = 5
) (
  input  wire                     clk,
  input  sst_pkg::sst_ctrl_t      ctrl_i,
  input  wire [WW-1:0]            count_i,
  input  wire [WW-1:0]            pos_i,
  input  sst_pkg::sst_entry_t     left_entry_i,
  input  wire                     left_gt_i,
  input  sst_pkg::sst_entry_t     right_entry_i,
  output sst_pkg::sst_entry_t     entry_o,
  output logic                    gt_o,
  output logic                    hit_o,
  output sst_pkg::sst_entry_t     rd_entry_o
);

  localparam logic [WW-1:0] MY_IDX = WW'(IDX);

  sst_pkg::sst_entry_t entry_r;
  sst_pkg::sst_entry_t entry_nxt;
  sst_pkg::sst_entry_t new_entry;
  logic                occ;

  // Occupancy and comparisons against the broadcast key
  assign occ   = (MY_IDX < count_i);
  assign gt_o  = occ && (entry_r.slot_time > ctrl_i.key);
  assign hit_o = occ && (entry_r.slot_time == ctrl_i.key)
                 && ((entry_r.slot_days & ctrl_i.days) != 7'd0);

  // Drive read data only when this slot is addressed
  assign rd_entry_o = (MY_IDX == pos_i) ? entry_r : '0;
  assign entry_o    = entry_r;

  assign new_entry.slot_time = ctrl_i.key;
  assign new_entry.slot_days = ctrl_i.days;

  // Insert shifts right from the insertion point; remove shifts left from pos
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.ins && (MY_IDX <= count_i)) begin
      if (left_gt_i) begin
        entry_nxt = left_entry_i;
      end else if (gt_o || (MY_IDX == count_i)) begin
        entry_nxt = new_entry;
      end
    end else if (ctrl_i.rem && (MY_IDX >= pos_i)) begin
      entry_nxt = right_entry_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

@@ design/sorted_schedule_table.sv @@
// Top level of the sorted schedule table: row of sst_cell slots plus output buffer.
// Depends on sst_pkg, sst_cell and assert_macros.svh.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall   | sst_pkg::sst_in_t
//   out_    | output    | out_valid/out_stall | sst_pkg::sst_out_t
//
// Every command finishes in the cycle it is accepted; its result beat is registered
// into out_ or the skid; one command per cycle is sustained while in_stall is low.
// All slots compare, shift or drive read data in parallel in the accepting cycle.
// A two-entry output buffer takes one more beat while a result is stalled;
// in_stall rises only when both entries are full.
// Reset clears the entry count and the output buffer; slot contents are not reset.
`default_nettype none

`include "assert_macros.svh"

module sorted_schedule_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  sst_pkg::sst_in_t    in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output sst_pkg::sst_out_t   out_data
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = (CW > 4) ? CW : 4;

  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [WW-1:0]       count_w;
  logic [WW-1:0]       pos_w;
  logic                accept;
  logic                full;
  logic                pos_ok;
  sst_pkg::sst_ctrl_t  ctrl;

  sst_pkg::sst_entry_t cell_ent [TABLE_DEPTH];
  sst_pkg::sst_entry_t cell_rd  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_gt;
  logic [TABLE_DEPTH-1:0] cell_hit;
  sst_pkg::sst_entry_t rd_entry;

  sst_pkg::sst_out_t   result;
  logic [CW+4:0]       count_ext;

  logic                out_valid_r;
  sst_pkg::sst_out_t   out_data_r;
  logic                skid_valid_r;
  sst_pkg::sst_out_t   skid_data_r;
  logic                pop;

  // Handshake
  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid_r;

  // Command decode
  assign count_w = WW'(count_r);
  assign pos_w   = WW'(in_data.position);
  assign full    = (count_r == CW'(TABLE_DEPTH));
  assign pos_ok  = (pos_w < count_w);

  assign ctrl.ins  = accept && (in_data.command == sst_pkg::CMD_INSERT) && !full;
  assign ctrl.rem  = accept && (in_data.command == sst_pkg::CMD_REMOVE) && pos_ok;
  assign ctrl.key  = in_data.minute_of_day;
  assign ctrl.days = in_data.day_mask;

  // Row of slots
  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    sst_pkg::sst_entry_t left_e;
    sst_pkg::sst_entry_t right_e;
    logic                left_g;

    if (gi == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_inner
      assign left_e = cell_ent[gi-1];
      assign left_g = cell_gt[gi-1];
    end

    if (gi == TABLE_DEPTH - 1) begin : g_last
      assign right_e = cell_ent[gi];
    end else begin : g_body
      assign right_e = cell_ent[gi+1];
    end

    sst_cell #(
      .IDX (gi),
      .WW  (WW)
    ) u_cell (
      .clk           (clk),
      .ctrl_i        (ctrl),
      .count_i       (count_w),
      .pos_i         (pos_w),
      .left_entry_i  (left_e),
      .left_gt_i     (left_g),
      .right_entry_i (right_e),
      .entry_o       (cell_ent[gi]),
      .gt_o          (cell_gt[gi]),
      .hit_o         (cell_hit[gi]),
      .rd_entry_o    (cell_rd[gi])
    );
  end

  // Merge the one-hot read data
  always_comb begin
    rd_entry = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      rd_entry = rd_entry | cell_rd[k];
    end
  end

  // Advance the entry count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Build the result beat
  assign count_ext = (CW + 5)'(count_nxt);

  always_comb begin
    result             = '0;
    result.entry_count = count_ext[4:0];
    case (in_data.command)
      sst_pkg::CMD_INSERT: begin
        if (full) begin
          result.status = sst_pkg::ST_FULL;
        end
      end
      sst_pkg::CMD_REMOVE: begin
        if (!pos_ok) begin
          result.status = sst_pkg::ST_BADPOS;
        end
      end
      sst_pkg::CMD_SEARCH: begin
        result.matched = |cell_hit;
      end
      sst_pkg::CMD_READ: begin
        if (!pos_ok) begin
          result.status = sst_pkg::ST_BADPOS;
        end else begin
          result.found_time = rd_entry.slot_time;
          result.found_days = rd_entry.slot_days;
        end
      end
      default: begin
        result.status = sst_pkg::ST_OK;
      end
    endcase
  end

  // Two-entry output buffer: hold a stalled beat, park one more in the skid
  assign pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `SST_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_r <= CW'(TABLE_DEPTH),
    "entry count beyond table depth")
  `SST_ASSERT_NOW(a_skid_order, clk, rst_n, skid_valid_r, out_valid_r,
    "skid entry held with empty output register")
  `SST_ASSERT_NEXT(a_search_keeps_count, clk, rst_n,
    accept && ((in_data.command == sst_pkg::CMD_SEARCH) ||
               (in_data.command == sst_pkg::CMD_READ)),
    count_r == $past(count_r), "search or read changed entry count")
  `SST_ASSERT_NEXT(a_beat_lands, clk, rst_n, accept, out_valid_r,
    "accepted command produced no result beat")

endmodule

`default_nettype wire

@@ sim/tb_sorted_schedule_table.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sorted_schedule_table: directed and random command beats.
// Depends on sst_pkg and the sorted_schedule_table RTL; keeps its own copy of the table.
module tb_sorted_schedule_table;

  localparam int DEPTH        = 16;
  localparam int RANDOM_BEATS = 525;
  localparam int STUCK_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  sst_pkg::sst_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  sst_pkg::sst_out_t out_data;

  sorted_schedule_table uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shadow copy of the schedule table
  logic [10:0] shadow_time [DEPTH];
  logic [6:0]  shadow_days [DEPTH];
  int          shadow_count = 0;

  sst_pkg::sst_in_t  command_queue [$];
  sst_pkg::sst_out_t expected_results [$];

  int   total_commands   = 0;
  int   commands_taken   = 0;
  int   results_taken    = 0;
  int   mismatches       = 0;
  int   stuck_cycles     = 0;
  int   full_hits        = 0;
  int   badpos_hits      = 0;
  int   search_hits      = 0;
  int   peak_fill        = 0;
  logic in_fire          = 1'b0;

  logic [10:0] time_pool [8] = '{11'd0, 11'd1, 11'd420, 11'd720,
                                 11'd721, 11'd1080, 11'd1439, 11'd2047};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one command to the shadow table and return the result it should give
  function automatic sst_pkg::sst_out_t schedule_apply(sst_pkg::sst_in_t beat);
    sst_pkg::sst_out_t res;
    int                at;
    res = '0;
    case (beat.command)
      sst_pkg::CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = sst_pkg::ST_FULL;
        end else begin
          // land after every entry with an equal or earlier time
          at = shadow_count;
          for (int k = 0; k < shadow_count; k++) begin
            if (shadow_time[k] > beat.minute_of_day && at == shadow_count) at = k;
          end
          for (int k = shadow_count; k > at; k--) begin
            shadow_time[k] = shadow_time[k-1];
            shadow_days[k] = shadow_days[k-1];
          end
          shadow_time[at] = beat.minute_of_day;
          shadow_days[at] = beat.day_mask;
          shadow_count++;
        end
      end
      sst_pkg::CMD_REMOVE: begin
        if (int'(beat.position) >= shadow_count) begin
          res.status = sst_pkg::ST_BADPOS;
        end else begin
          // close the gap
          for (int k = beat.position; k + 1 < shadow_count; k++) begin
            shadow_time[k] = shadow_time[k+1];
            shadow_days[k] = shadow_days[k+1];
          end
          shadow_count--;
        end
      end
      sst_pkg::CMD_SEARCH: begin
        for (int k = 0; k < shadow_count; k++) begin
          if (shadow_time[k] == beat.minute_of_day &&
              (shadow_days[k] & beat.day_mask) != 0)
            res.matched = 1'b1;
        end
      end
      default: begin
        if (int'(beat.position) >= shadow_count) begin
          res.status = sst_pkg::ST_BADPOS;
        end else begin
          res.found_time = shadow_time[beat.position];
          res.found_days = shadow_days[beat.position];
        end
      end
    endcase
    res.entry_count = 5'(shadow_count);
    return res;
  endfunction

  function automatic void push_command(logic [1:0] cmd, logic [10:0] minute,
                                       logic [6:0] days, logic [3:0] pos);
    sst_pkg::sst_in_t beat;
    beat.command       = cmd;
    beat.minute_of_day = minute;
    beat.day_mask      = days;
    beat.position      = pos;
    command_queue.push_back(beat);
  endfunction

  // Mostly times from a small pool so searches hit; sometimes any 11-bit value
  function automatic logic [10:0] pick_time();
    if ($urandom_range(0, 3) == 0) return 11'($urandom);
    return time_pool[$urandom_range(0, 7)];
  endfunction

  // Drive the input channel; hold a beat until it is taken
  always @(negedge clk) begin
    int send_idle;
    int recv_idle;
    send_idle = 0;
    recv_idle = 0;
    if (total_commands > 0) begin
      case (commands_taken * 3 / total_commands)
        0:       begin send_idle = 32; recv_idle = 60; end
        1:       begin send_idle = 60; recv_idle = 32; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (command_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        in_data  <= command_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Predict on each accepted command, check each accepted result
  always @(posedge clk) begin
    sst_pkg::sst_out_t want;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;

      if (in_valid && !in_stall) begin
        want = schedule_apply(in_data);
        expected_results.push_back(want);
        commands_taken++;
        if (want.status == sst_pkg::ST_FULL) full_hits++;
        if (want.status == sst_pkg::ST_BADPOS) badpos_hits++;
        if (want.matched) search_hits++;
        if (shadow_count > peak_fill) peak_fill = shadow_count;
      end

      if (out_valid && !out_stall) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result beat with nothing expected: %p", $realtime, out_data);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status      !== want.status     ||
              out_data.matched     !== want.matched    ||
              out_data.found_time  !== want.found_time ||
              out_data.found_days  !== want.found_days ||
              out_data.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"[%0t] result %0d: expected st=%0d hit=%0d t=%0d d=%h n=%0d,",
                        " got st=%0d hit=%0d t=%0d d=%h n=%0d"},
                       $realtime, results_taken,
                       want.status, want.matched, want.found_time,
                       want.found_days, want.entry_count,
                       out_data.status, out_data.matched, out_data.found_time,
                       out_data.found_days, out_data.entry_count);
          end
        end
      end
    end
  end

  // Watchdog: stop when nothing moves for too long
  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("no handshake for %0d cycles, %0d of %0d commands taken",
             STUCK_LIMIT, commands_taken, total_commands);
    $display("sorted_schedule_table: mismatch");
    $finish;
  end

  // Build the stimulus, release reset, wait for the table to drain
  initial begin
    int          insert_pct;
    int          roll;
    logic [6:0]  days;
    logic [3:0]  pos;

    // empty table: bad positions and a search with nothing stored
    push_command(sst_pkg::CMD_READ,   11'd0,    7'h7f, 4'd0);
    push_command(sst_pkg::CMD_REMOVE, 11'd0,    7'h00, 4'd15);
    push_command(sst_pkg::CMD_SEARCH, 11'd0,    7'h7f, 4'd0);
    // time extremes, an equal time placed after the first, an empty mask
    push_command(sst_pkg::CMD_INSERT, 11'd720,  7'h01, 4'd0);
    push_command(sst_pkg::CMD_INSERT, 11'd0,    7'h7f, 4'd0);
    push_command(sst_pkg::CMD_INSERT, 11'd2047, 7'h40, 4'd15);
    push_command(sst_pkg::CMD_INSERT, 11'd720,  7'h02, 4'd0);
    push_command(sst_pkg::CMD_INSERT, 11'd1439, 7'h00, 4'd0);
    push_command(sst_pkg::CMD_SEARCH, 11'd720,  7'h02, 4'd0);
    push_command(sst_pkg::CMD_SEARCH, 11'd1439, 7'h7f, 4'd0);
    push_command(sst_pkg::CMD_SEARCH, 11'd720,  7'h00, 4'd0);
    push_command(sst_pkg::CMD_READ,   11'd0,    7'h00, 4'd2);
    // fill to capacity, then one insert too many
    for (int k = 1; k <= 11; k++)
      push_command(sst_pkg::CMD_INSERT, 11'(k * 100), 7'(k), 4'(k));
    push_command(sst_pkg::CMD_INSERT, 11'd500,  7'h55, 4'd0);
    push_command(sst_pkg::CMD_READ,   11'd0,    7'h00, 4'd15);
    push_command(sst_pkg::CMD_REMOVE, 11'd0,    7'h00, 4'd15);
    push_command(sst_pkg::CMD_REMOVE, 11'd0,    7'h00, 4'd0);
    push_command(sst_pkg::CMD_READ,   11'd0,    7'h00, 4'd14);

    // random: alternate fill-heavy and drain-heavy stretches
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      insert_pct = ((n / 48) % 2 == 0) ? 70 : 10;
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) days = ($urandom_range(0, 1) != 0) ? 7'h7f : 7'h00;
      else days = 7'($urandom_range(0, 127));
      pos = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(0, 3));
      if (roll < insert_pct) begin
        push_command(sst_pkg::CMD_INSERT, pick_time(), days, pos);
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    push_command(sst_pkg::CMD_REMOVE, 11'($urandom), days, pos);
          2:       push_command(sst_pkg::CMD_SEARCH, pick_time(), days, pos);
          default: push_command(sst_pkg::CMD_READ, 11'($urandom), days, pos);
        endcase
      end
    end
    total_commands = command_queue.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(commands_taken == total_commands && expected_results.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands and %0d results: %0d full, %0d bad position,",
             commands_taken, results_taken, full_hits, badpos_hits);
    $display("%0d search hits, peak fill %0d of %0d entries, %0d mismatches",
             search_hits, peak_fill, DEPTH, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("sorted_schedule_table: match");
    end else begin
      $display("sorted_schedule_table: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/sst_pkg.sv
design/sst_cell.sv
design/sorted_schedule_table.sv
sim/tb_sorted_schedule_table.sv
